FILE: hw/rtl/imfd_pkg.sv
// shared types and constants of the ip/mac binding flip detector
// no dependencies

package imfd_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] HASH_MULT = 32'd2654435761;
   localparam logic [15:0] DEFAULT_THRESHOLD = 16'd3;
   localparam logic [15:0] FLIPS_MAX = 16'hFFFF;
   localparam logic [31:0] ALERTS_MAX = 32'hFFFF_FFFF;

   localparam logic [1:0] OUTCOME_NEW = 2'd0;
   localparam logic [1:0] OUTCOME_SEEN = 2'd1;
   localparam logic [1:0] OUTCOME_FULL = 2'd2;

   typedef struct packed {
      logic [31:0] ip_address;
      logic [47:0] mac_address;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic        spoof_alert;
      logic [15:0] flip_tally;
      logic [31:0] alert_total;
   } rsp_item_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [31:0]      ip;
      logic [47:0]      mac;
      logic [IDX_W-1:0] slot;
   } work_item_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] flips;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

FILE: hw/rtl/imfd_front.sv
// front end: accepts requests and computes the home slot by multiplicative hash
// depends on imfd_pkg

module imfd_front import imfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  req_item_type  req_item,
   input  logic          q_full,
   output logic          q_push,
   output work_item_type q_item
);

   logic          stage_valid_ff, stage_valid_in;
   work_item_type stage_item_ff, stage_item_in;
   logic [31:0]   product;
   logic          accept;

   assign product = req_item.ip_address * HASH_MULT;
   assign full    = stage_valid_ff & q_full;
   assign accept  = push & ~full;
   assign q_push  = stage_valid_ff & ~q_full;
   assign q_item  = stage_item_ff;

   always_comb begin
      stage_valid_in = accept | (stage_valid_ff & q_full);
      stage_item_in  = stage_item_ff;
      if (accept) begin
         stage_item_in.ip   = req_item.ip_address;
         stage_item_in.mac  = req_item.mac_address;
         stage_item_in.slot = IDX_W'(product % TABLE_ENTRIES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

endmodule

FILE: hw/rtl/imfd_queue.sv
// short request queue between front and back
// depends on imfd_pkg

module imfd_queue import imfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   input  work_item_type    q_in_item,
   input  logic             q_pop,
   output work_item_type    q_out_item,
   output queue_status_type q_status
);

   work_item_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_out_item     = entry_ff[rptr_ff];
   assign do_push        = q_push & ~q_status.full;
   assign do_pop         = q_pop & q_status.valid;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wptr_ff] <= q_in_item;
      end
   end

endmodule

FILE: hw/rtl/imfd_back.sv
// back end: linear probe sequencer over the binding table, flip and alert
// counting, threshold register and result register; depends on imfd_pkg

module imfd_back import imfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  work_item_type    q_item,
   output logic             q_pop,
   input  logic             valid,
   output logic             ready,
   input  logic [15:0]      csr_wdata,
   output logic             empty,
   input  logic             pop,
   output rsp_item_type     rsp_item
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   entry_type             table_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] slot_valid_ff;
   entry_type             rd_entry_ff;
   logic                  rd_valid_ff;

   logic [1:0]       state_ff, state_in;
   logic [31:0]      ip_ff, ip_in;
   logic [47:0]      mac_ff, mac_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      total_ff, total_in;
   logic [15:0]      threshold_ff, threshold_in;
   rsp_item_type     res_ff, res_in;
   rsp_item_type     out_item_ff, out_item_in;
   logic             out_valid_ff, out_valid_in;

   logic        wr_en;
   entry_type   wr_entry;
   logic [15:0] thr;
   logic [15:0] flips_next;
   logic        alert;
   logic [31:0] total_next;

   assign ready    = 1'b1;
   assign empty    = ~out_valid_ff;
   assign rsp_item = out_item_ff;
   assign thr      = (threshold_ff == '0) ? DEFAULT_THRESHOLD : threshold_ff;

   always_comb begin
      flips_next = (rd_entry_ff.flips != FLIPS_MAX) ? rd_entry_ff.flips + 1'b1
                                                    : rd_entry_ff.flips;
      alert      = (rd_entry_ff.mac != mac_ff) && (flips_next >= thr);
      total_next = (alert && total_ff != ALERTS_MAX) ? total_ff + 1'b1 : total_ff;
   end

   always_comb begin
      state_in     = state_ff;
      ip_in        = ip_ff;
      mac_in       = mac_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      out_item_in  = out_item_ff;
      out_valid_in = out_valid_ff;
      threshold_in = (valid && ready) ? csr_wdata : threshold_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_entry     = '{ip: ip_ff, mac: mac_ff, flips: '0};

      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.valid) begin
               q_pop    = 1'b1;
               ip_in    = q_item.ip;
               mac_in   = q_item.mac;
               idx_in   = q_item.slot;
               cnt_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!rd_valid_ff) begin
               wr_en    = 1'b1;
               res_in   = '{outcome: OUTCOME_NEW, spoof_alert: 1'b0,
                            flip_tally: '0, alert_total: total_ff};
               state_in = ST_DONE;
            end else if (rd_entry_ff.ip == ip_ff) begin
               if (rd_entry_ff.mac != mac_ff) begin
                  wr_en    = 1'b1;
                  wr_entry = '{ip: ip_ff, mac: mac_ff, flips: flips_next};
                  res_in   = '{outcome: OUTCOME_SEEN, spoof_alert: alert,
                               flip_tally: flips_next, alert_total: total_next};
               end else begin
                  res_in   = '{outcome: OUTCOME_SEEN, spoof_alert: 1'b0,
                               flip_tally: rd_entry_ff.flips, alert_total: total_ff};
               end
               total_in = total_next;
               state_in = ST_DONE;
            end else if (cnt_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               res_in   = '{outcome: OUTCOME_FULL, spoof_alert: 1'b0,
                            flip_tally: '0, alert_total: total_ff};
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               idx_in   = (idx_ff == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || pop) begin
               out_valid_in = 1'b1;
               out_item_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // binding table, one read or one write per cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_entry_ff <= table_ff[idx_ff];
      end
      if (wr_en) begin
         table_ff[idx_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         threshold_ff  <= DEFAULT_THRESHOLD;
         out_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            slot_valid_ff[idx_ff] <= 1'b1;
         end
         rd_valid_ff  <= slot_valid_ff[idx_ff];
         state_ff     <= state_in;
         total_ff     <= total_in;
         threshold_ff <= threshold_in;
         out_valid_ff <= out_valid_in;
      end
      ip_ff       <= ip_in;
      mac_ff      <= mac_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      out_item_ff <= out_item_in;
   end

endmodule

FILE: hw/rtl/ip_mac_binding_flip_detector_core.sv
// ip/mac binding flip detector, top level
// depends on imfd_pkg, imfd_front, imfd_queue, imfd_back

// Each request carries an observed IPv4 address and MAC address. The front end
// hashes the address into a home slot and parks the request in a two-entry
// queue; the back end probes a 256-slot table linearly, one slot per read
// state and check state through its single table port. A request is popped
// from the queue in the idle state, probed slot by slot, and its result held
// in the done state until the output register is free. Requests keep being
// taken while a result waits to be popped, until the queue fills. The table is
// empty after reset, with no clearing pass. A threshold of zero acts as 3.

module ip_mac_binding_flip_detector_core import imfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item,
   input  logic         valid,
   output logic         ready,
   input  logic [15:0]  csr_wdata
);

   logic             q_push;
   logic             q_pop;
   work_item_type    q_in_item;
   work_item_type    q_out_item;
   queue_status_type q_status;

   imfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .q_full   (q_status.full),
      .q_push   (q_push),
      .q_item   (q_in_item)
   );

   imfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_push     (q_push),
      .q_in_item  (q_in_item),
      .q_pop      (q_pop),
      .q_out_item (q_out_item),
      .q_status   (q_status)
   );

   imfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_item    (q_out_item),
      .q_pop     (q_pop),
      .valid     (valid),
      .ready     (ready),
      .csr_wdata (csr_wdata),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: verif/tb_ip_mac_binding_flip_detector_core.sv
`timescale 1ns / 100ps
// testbench for ip_mac_binding_flip_detector_core: streams ip/mac observations through
// the queue ports and checks every response against a local binding table
// depends on imfd_pkg and the core rtl

module tb_ip_mac_binding_flip_detector_core;
   import imfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int POOL_SIZE = 48;
   localparam int FLIP_RUN = 20;

   typedef enum logic [1:0] {STIM_OBSERVE, STIM_THRESHOLD, STIM_DRAIN} stim_kind_type;

   typedef struct {
      stim_kind_type kind;
      req_item_type  item;
      logic [15:0]   thr;
      bit            no_gap;
   } stim_entry_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         full;
   req_item_type req_item = '0;
   logic         empty;
   logic         pop = 1'b0;
   rsp_item_type rsp_item;
   logic         valid = 1'b0;
   logic         ready;
   logic [15:0]  csr_wdata = '0;

   stim_entry_type observation_q[$];
   rsp_item_type   pending_verdict_q[$];

   // local copy of the binding table
   bit           slot_used [TABLE_ENTRIES];
   logic [31:0]  slot_ip [TABLE_ENTRIES];
   logic [47:0]  slot_mac [TABLE_ENTRIES];
   logic [15:0]  slot_flips [TABLE_ENTRIES];
   logic [31:0]  alert_count = '0;
   logic [15:0]  thr_reg = DEFAULT_THRESHOLD;

   logic [31:0]  pool_ip [POOL_SIZE];
   logic [47:0]  pool_mac [POOL_SIZE][3];

   bit           req_taken = 1'b0;
   bit           rsp_taken = 1'b0;
   bit           csr_taken = 1'b0;
   bit           no_idle = 1'b0;
   bit           timed_out = 1'b0;
   int           send_gap = 0;
   int           take_gap = 0;
   int           settle_cycles = 0;
   int           idle_cycles = 0;
   int           mismatches = 0;

   ip_mac_binding_flip_detector_core DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .valid     (valid),
      .ready     (ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_item_type predict_binding(req_item_type obs);
      rsp_item_type res;
      logic [31:0]  product;
      logic [15:0]  limit;
      int           at;
      bit           placed;
      product = obs.ip_address * HASH_MULT;
      at = int'(product % TABLE_ENTRIES);
      limit = (thr_reg == '0) ? DEFAULT_THRESHOLD : thr_reg;
      res = '0;
      res.outcome = OUTCOME_FULL;
      placed = 1'b0;
      for (int n = 0; n < TABLE_ENTRIES && !placed; n++) begin
         if (!slot_used[at]) begin
            slot_used[at] = 1'b1;
            slot_ip[at] = obs.ip_address;
            slot_mac[at] = obs.mac_address;
            slot_flips[at] = '0;
            res.outcome = OUTCOME_NEW;
            placed = 1'b1;
         end else if (slot_ip[at] == obs.ip_address) begin
            res.outcome = OUTCOME_SEEN;
            if (slot_mac[at] != obs.mac_address) begin
               if (slot_flips[at] != FLIPS_MAX) slot_flips[at] = slot_flips[at] + 16'd1;
               slot_mac[at] = obs.mac_address;
               if (slot_flips[at] >= limit) begin
                  if (alert_count != ALERTS_MAX) alert_count = alert_count + 32'd1;
                  res.spoof_alert = 1'b1;
               end
            end
            res.flip_tally = slot_flips[at];
            placed = 1'b1;
         end else begin
            at = (at == TABLE_ENTRIES - 1) ? 0 : at + 1;
         end
      end
      res.alert_total = alert_count;
      return res;
   endfunction

   function automatic logic [47:0] rand_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic add_observe(logic [31:0] ip, logic [47:0] mac, bit no_gap);
      stim_entry_type e;
      e.kind = STIM_OBSERVE;
      e.item.ip_address = ip;
      e.item.mac_address = mac;
      e.thr = '0;
      e.no_gap = no_gap;
      observation_q.push_back(e);
   endtask

   task automatic add_threshold(logic [15:0] value);
      stim_entry_type e;
      e.kind = STIM_THRESHOLD;
      e.item = '0;
      e.thr = value;
      e.no_gap = 1'b0;
      observation_q.push_back(e);
   endtask

   task automatic add_drain();
      stim_entry_type e;
      e.kind = STIM_DRAIN;
      e.item = '0;
      e.thr = '0;
      e.no_gap = 1'b0;
      observation_q.push_back(e);
   endtask

   task automatic add_random_mix(int count);
      for (int i = 0; i < count; i++) begin
         int pick;
         bit calm;
         calm = ((i / 24) % 3) == 1;
         if ($urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            add_observe(pool_ip[pick], pool_mac[pick][$urandom_range(0, 2)], calm);
         end else begin
            add_observe($urandom, rand_mac(), calm);
         end
      end
   endtask

   // request and config driver
   always @(negedge clock) begin
      logic drive_push;
      logic drive_csr;
      drive_push = push;
      drive_csr = valid;
      if (reset) begin
         drive_push = 1'b0;
         drive_csr = 1'b0;
      end else begin
         if (push && req_taken) begin
            drive_push = 1'b0;
            send_gap = no_idle ? 0 : $urandom_range(0, 16);
         end
         if (valid && csr_taken) drive_csr = 1'b0;
         if (pending_verdict_q.size() == 0 && !drive_push) settle_cycles++;
         else settle_cycles = 0;
         if (!drive_push && !drive_csr && observation_q.size() > 0) begin
            if (send_gap > 0) begin
               send_gap--;
            end else begin
               unique case (observation_q[0].kind)
                  STIM_OBSERVE: begin
                     drive_push = 1'b1;
                     req_item <= observation_q[0].item;
                     no_idle = observation_q[0].no_gap;
                     observation_q.delete(0);
                  end
                  STIM_THRESHOLD: begin
                     if (settle_cycles >= SETTLE_CYCLES) begin
                        drive_csr = 1'b1;
                        csr_wdata <= observation_q[0].thr;
                        observation_q.delete(0);
                     end
                  end
                  default: begin
                     if (settle_cycles >= SETTLE_CYCLES) observation_q.delete(0);
                  end
               endcase
            end
         end
      end
      push <= drive_push;
      valid <= drive_csr;
   end

   // response side stalls
   always @(negedge clock) begin
      logic drive_pop;
      drive_pop = 1'b0;
      if (!reset) begin
         if (rsp_taken) take_gap = no_idle ? 0 : $urandom_range(0, 16);
         if (take_gap > 0) begin
            if (!empty) take_gap--;
         end else begin
            drive_pop = 1'b1;
         end
      end
      pop <= drive_pop;
   end

   // handshake sampling, prediction and checking
   always @(posedge clock) begin
      rsp_item_type want;
      req_taken = !reset && push && !full;
      rsp_taken = !reset && pop && !empty;
      csr_taken = !reset && valid && ready;
      if (csr_taken) thr_reg = csr_wdata;
      if (rsp_taken) begin
         if (pending_verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p at %0t", rsp_item, $time);
         end else begin
            want = pending_verdict_q.pop_front();
            if (rsp_item.outcome !== want.outcome || rsp_item.spoof_alert !== want.spoof_alert
                || rsp_item.flip_tally !== want.flip_tally
                || rsp_item.alert_total !== want.alert_total) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch at %0t: outcome %0d/%0d alert %0d/%0d flips %0d/%0d",
                            " total %0d/%0d (expected/actual)"}, $time,
                           want.outcome, rsp_item.outcome, want.spoof_alert,
                           rsp_item.spoof_alert, want.flip_tally, rsp_item.flip_tally,
                           want.alert_total, rsp_item.alert_total);
            end
         end
      end
      if (req_taken) pending_verdict_q.push_back(predict_binding(req_item));
      if (reset || req_taken || rsp_taken || csr_taken) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
   end

   initial begin
      logic [31:0] base;
      logic [47:0] mac_a;
      logic [47:0] mac_b;

      // directed: new, repeat, flips up to the default threshold, probing and wrap
      add_observe(32'h0000_0000, 48'h0000_0000_0000, 1'b0);
      add_observe(32'h0000_0000, 48'h0000_0000_0000, 1'b0);
      add_observe(32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
      add_observe(32'h0000_0000, 48'h0000_0000_0000, 1'b0);
      add_observe(32'h0000_0000, 48'h0000_0000_0001, 1'b0);
      add_observe(32'h0000_0000, 48'h0000_0000_0001, 1'b0);
      add_observe(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
      add_observe(32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1);
      add_observe(32'h0000_0100, 48'h0123_4567_89AB, 1'b1);
      add_observe(32'h0000_0200, 48'hA5A5_5A5A_A5A5, 1'b0);
      add_observe(32'h0000_0100, 48'h5A5A_A5A5_5A5A, 1'b0);
      add_observe(32'h0000_0000, 48'h0000_0000_0002, 1'b0);
      add_observe(32'h0000_0200, 48'hA5A5_5A5A_A5A5, 1'b0);
      // home slot is the last one, so these wrap round to the start
      add_observe(32'h0000_00AF, 48'h1111_2222_3333, 1'b0);
      add_observe(32'h0000_01AF, 48'h4444_5555_6666, 1'b0);
      add_observe(32'h0000_02AF, 48'h7777_8888_9999, 1'b0);
      add_observe(32'h0000_01AF, 48'h4444_5555_6667, 1'b0);
      add_observe(32'h0000_02AF, 48'h7777_8888_999A, 1'b0);

      // groups of four addresses sharing one home slot
      for (int k = 0; k < POOL_SIZE; k++) begin
         if (k % 4 == 0) base = $urandom;
         pool_ip[k] = base + (32'(k % 4) << 8);
         for (int m = 0; m < 3; m++) pool_mac[k][m] = rand_mac();
      end

      add_threshold(16'h0000);
      add_random_mix(60);
      add_drain();
      add_threshold(16'h0001);
      add_random_mix(60);
      add_threshold(16'($urandom_range(2, 6)));
      add_random_mix(60);
      add_drain();
      add_random_mix(60);

      // repeated flips on one address under a high threshold, streamed with no idling
      add_threshold(16'hFFFF);
      mac_a = rand_mac();
      mac_b = ~mac_a;
      add_observe(32'hC0A8_0A01, mac_a, 1'b1);
      for (int i = 1; i <= FLIP_RUN; i++) add_observe(32'hC0A8_0A01, (i % 2) ? mac_b : mac_a, 1'b1);
      add_observe(32'hC0A8_0A01, (FLIP_RUN % 2) ? mac_b : mac_a, 1'b1);

      // fill the table, then new addresses find it full, known ones still hit
      add_threshold(16'($urandom_range(0, 65535)));
      for (int i = 0; i < 256; i++) add_observe(32'h0A00_0000 + i, rand_mac(), 1'b0);
      for (int i = 0; i < 8; i++) add_observe($urandom, rand_mac(), 1'b0);
      for (int i = 0; i < 8; i++) add_observe(pool_ip[$urandom_range(0, POOL_SIZE - 1)],
                                              rand_mac(), 1'b0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (!timed_out && (observation_q.size() > 0 || push || valid
                            || pending_verdict_q.size() > 0))
         @(posedge clock);
      if (!timed_out) repeat (20) @(posedge clock);
      if (mismatches == 0 && !timed_out) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/imfd_pkg.sv
hw/rtl/imfd_front.sv
hw/rtl/imfd_queue.sv
hw/rtl/imfd_back.sv
hw/rtl/ip_mac_binding_flip_detector_core.sv
verif/tb_ip_mac_binding_flip_detector_core.sv
